// ----- rtl/lcag_pkg.sv -----
package lcag_pkg;

    // Field widths
    localparam int unsigned LEVEL_W  = 18;
    localparam int unsigned DRIVE_W  = 8;
    localparam int unsigned TIME_W   = 32;
    localparam int unsigned SETTLE_W = 16;
    localparam int unsigned EFF_W    = LEVEL_W + 1;        // level * 3/2 fits here
    localparam int unsigned PROD_W   = DRIVE_W + LEVEL_W;  // drive * goal
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 18;
    localparam int unsigned S_DATA_W = 56;                 // level + now_ms, padded
    localparam int unsigned M_DATA_W = 16;                 // changed + drive + flush, padded

    // Restoring divider: one quotient bit per step
    localparam int unsigned DIV_STEPS = PROD_W;
    localparam int unsigned CNT_W     = $clog2(DIV_STEPS + 1);

    // Readings at or above this level are scaled by 3/2
    localparam logic [LEVEL_W-1:0] SAT_LEVEL = 18'd260000;

    // Register reset values
    localparam logic [DRIVE_W-1:0]  RST_DEFAULT_CURRENT = 8'd31;
    localparam logic [LEVEL_W-1:0]  RST_BAND_LOW        = 18'd50000;
    localparam logic [LEVEL_W-1:0]  RST_BAND_HIGH       = 18'd200000;
    localparam logic [LEVEL_W-1:0]  RST_DC_GOAL         = 18'd120000;
    localparam logic [DRIVE_W-1:0]  RST_DRIVE_MIN       = 8'd1;
    localparam logic [DRIVE_W-1:0]  RST_DRIVE_MAX       = 8'd255;
    localparam logic [SETTLE_W-1:0] RST_SETTLE_MS       = 16'd1000;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DEFAULT_CURRENT = 3'd0,
        REG_BAND_LOW        = 3'd1,
        REG_BAND_HIGH       = 3'd2,
        REG_DC_GOAL         = 3'd3,
        REG_DRIVE_MIN       = 3'd4,
        REG_DRIVE_MAX       = 3'd5,
        REG_SETTLE_MS       = 3'd6
    } t_reg_idx;

    // Datapath operations
    typedef enum logic [2:0] {
        OP_NONE    = 3'd0,
        OP_LOAD    = 3'd1,   // offer input ready, capture on a transaction
        OP_PREP    = 3'd2,   // product, effective level, divider init
        OP_DIV     = 3'd3,   // one restoring division step
        OP_CLAMP   = 3'd4,   // limit quotient and apply a proportional change
        OP_RESTORE = 3'd5,   // return to the default drive
        OP_EMIT    = 3'd6    // write the output register
    } t_op;

    // Jump conditions
    typedef enum logic [2:0] {
        C_NEVER       = 3'd0,
        C_ALWAYS      = 3'd1,
        C_NO_INPUT    = 3'd2,
        C_NOT_WORN    = 3'd3,
        C_HOLD        = 3'd4,
        C_DIV_BUSY    = 3'd5,
        C_OUT_BLOCKED = 3'd6
    } t_cond;

    localparam int unsigned STEP_W = 3;
    typedef logic [STEP_W-1:0] t_step;

    typedef struct packed {
        t_op   op;
        t_cond cond;
        t_step target;
    } t_ctrl;

    // Status flags the sequencer branches on
    typedef struct packed {
        logic no_input;
        logic not_worn;
        logic hold;
        logic div_busy;
        logic out_blocked;
    } t_stat;

    localparam t_step S_IDLE    = 3'd0;
    localparam t_step S_DECIDE  = 3'd1;
    localparam t_step S_CHECK   = 3'd2;
    localparam t_step S_PREP    = 3'd3;
    localparam t_step S_DIV     = 3'd4;
    localparam t_step S_CLAMP   = 3'd5;
    localparam t_step S_RESTORE = 3'd6;
    localparam t_step S_EMIT    = 3'd7;

    // Microprogram; falling through from the last step wraps to idle
    function automatic t_ctrl ucode(input t_step addr);
        t_ctrl w;
        unique case (addr)
            S_IDLE:    w = '{op: OP_LOAD,    cond: C_NO_INPUT,    target: S_IDLE};
            S_DECIDE:  w = '{op: OP_NONE,    cond: C_NOT_WORN,    target: S_RESTORE};
            S_CHECK:   w = '{op: OP_NONE,    cond: C_HOLD,        target: S_EMIT};
            S_PREP:    w = '{op: OP_PREP,    cond: C_NEVER,       target: S_IDLE};
            S_DIV:     w = '{op: OP_DIV,     cond: C_DIV_BUSY,    target: S_DIV};
            S_CLAMP:   w = '{op: OP_CLAMP,   cond: C_ALWAYS,      target: S_EMIT};
            S_RESTORE: w = '{op: OP_RESTORE, cond: C_NEVER,       target: S_IDLE};
            S_EMIT:    w = '{op: OP_EMIT,    cond: C_OUT_BLOCKED, target: S_EMIT};
            default:   w = '{op: OP_NONE,    cond: C_ALWAYS,      target: S_IDLE};
        endcase
        return w;
    endfunction

endpackage

// ----- rtl/lcag_seq.sv -----
module lcag_seq (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  lcag_pkg::t_stat i_stat,
    output lcag_pkg::t_ctrl o_ctrl
);
    import lcag_pkg::*;

    t_step r_step;
    t_step n_step;
    t_ctrl w_ctrl;
    logic  w_jump;

    // Control word lookup
    assign w_ctrl = ucode(r_step);
    assign o_ctrl = w_ctrl;

    // Branch condition select
    always_comb begin
        unique case (w_ctrl.cond)
            C_NEVER:       w_jump = 1'b0;
            C_ALWAYS:      w_jump = 1'b1;
            C_NO_INPUT:    w_jump = i_stat.no_input;
            C_NOT_WORN:    w_jump = i_stat.not_worn;
            C_HOLD:        w_jump = i_stat.hold;
            C_DIV_BUSY:    w_jump = i_stat.div_busy;
            C_OUT_BLOCKED: w_jump = i_stat.out_blocked;
            default:       w_jump = 1'b0;
        endcase
        n_step = w_jump ? w_ctrl.target : r_step + t_step'(1);
    end

    // Step counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= S_IDLE;
        end else begin
            r_step <= n_step;
        end
    end

endmodule

// ----- rtl/led_current_auto_gain.sv -----
// LED drive auto-gain. Each input transaction carries an 18-bit block-average
// IR DC level (tdata bits 17:0), a millisecond timestamp (tdata bits 49:18)
// and the worn flag (tuser); each one yields exactly one output transaction
// with the changed flag, the drive value now in effect and a FIFO-flush
// request. One transaction is processed at a time under a small microcoded
// sequencer. An item that calls for a proportional correction passes from
// acceptance to output through capture, two decision steps, one setup step,
// 26 steps of the bit-serial restoring divider (one quotient bit per cycle,
// set by the 26-bit drive * goal product), a clamp step and the output write.
// Items that need no division (not worn, inside the settle window, inside the
// band or zero) skip the divider. The output register holds a finished
// result while the sequencer returns to idle, so the next item is accepted
// while the previous result still waits. Configuration registers are written
// through the cfg channel, which is ready whenever the block is out of reset,
// and should change only while the block is idle.
module led_current_auto_gain (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // Input stream
    input  logic                              i_s_tvalid,
    output logic                              o_s_tready,
    input  logic [lcag_pkg::S_DATA_W-1:0]     i_s_tdata,   // ir_level[17:0], now_ms[49:18]
    input  logic                              i_s_tuser,   // worn
    // Output stream
    output logic                              o_m_tvalid,
    input  logic                              i_m_tready,
    output logic [lcag_pkg::M_DATA_W-1:0]     o_m_tdata,   // changed[0], drive[8:1], flush_fifo[9]
    // Configuration writes
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [lcag_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [lcag_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import lcag_pkg::*;

    // Configuration registers
    logic [DRIVE_W-1:0]  r_default_current;
    logic [LEVEL_W-1:0]  r_band_low;
    logic [LEVEL_W-1:0]  r_band_high;
    logic [LEVEL_W-1:0]  r_dc_goal;
    logic [DRIVE_W-1:0]  r_drive_min;
    logic [DRIVE_W-1:0]  r_drive_max;
    logic [SETTLE_W-1:0] r_settle_ms;

    // Block state
    logic [DRIVE_W-1:0]  r_drive;
    logic [TIME_W-1:0]   r_last_ms;

    // Captured item and working registers
    logic [LEVEL_W-1:0]  r_level;
    logic                r_worn;
    logic [TIME_W-1:0]   r_now;
    logic [EFF_W-1:0]    r_eff;
    logic [PROD_W-1:0]   r_quo;
    logic [EFF_W-1:0]    r_rem;
    logic [CNT_W-1:0]    r_cnt;
    logic                r_chg;
    logic                r_flush;

    // Output register
    logic                r_m_valid;
    logic [M_DATA_W-1:0] r_m_data;

    t_ctrl w_ctrl;
    t_stat w_stat;

    logic                w_s_acc;
    logic [TIME_W-1:0]   w_elapsed;
    logic                w_in_band;
    logic [EFF_W:0]      w_rem_sh;
    logic [EFF_W:0]      w_rem_sub;
    logic                w_q_bit;
    logic [PROD_W-1:0]   w_lo;
    logic [DRIVE_W-1:0]  w_limited;

    lcag_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stat  (w_stat),
        .o_ctrl  (w_ctrl)
    );

    // Handshakes
    assign o_s_tready = i_rst_n && (w_ctrl.op == OP_LOAD);
    assign w_s_acc    = i_s_tvalid && o_s_tready;
    assign o_cfg_ready = i_rst_n;
    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = r_m_data;

    // Decision terms
    assign w_elapsed = r_now - r_last_ms;
    assign w_in_band = (r_level >= r_band_low) && (r_level <= r_band_high);

    assign w_stat.no_input    = !i_s_tvalid;
    assign w_stat.not_worn    = !r_worn;
    assign w_stat.hold        = (w_elapsed < TIME_W'(r_settle_ms)) || w_in_band
                                || (r_level == '0);
    assign w_stat.div_busy    = (r_cnt != CNT_W'(1));
    assign w_stat.out_blocked = r_m_valid && !i_m_tready;

    // One restoring division step
    assign w_rem_sh  = {r_rem, r_quo[PROD_W-1]};
    assign w_rem_sub = w_rem_sh - {1'b0, r_eff};
    assign w_q_bit   = !w_rem_sub[EFF_W];

    // Raise to drive_min, then lower to drive_max
    assign w_lo      = (r_quo < PROD_W'(r_drive_min)) ? PROD_W'(r_drive_min) : r_quo;
    assign w_limited = (w_lo > PROD_W'(r_drive_max)) ? r_drive_max : w_lo[DRIVE_W-1:0];

    // Configuration register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_default_current <= RST_DEFAULT_CURRENT;
            r_band_low        <= RST_BAND_LOW;
            r_band_high       <= RST_BAND_HIGH;
            r_dc_goal         <= RST_DC_GOAL;
            r_drive_min       <= RST_DRIVE_MIN;
            r_drive_max       <= RST_DRIVE_MAX;
            r_settle_ms       <= RST_SETTLE_MS;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (t_reg_idx'(i_cfg_index))
                REG_DEFAULT_CURRENT: r_default_current <= i_cfg_data[DRIVE_W-1:0];
                REG_BAND_LOW:        r_band_low        <= i_cfg_data[LEVEL_W-1:0];
                REG_BAND_HIGH:       r_band_high       <= i_cfg_data[LEVEL_W-1:0];
                REG_DC_GOAL:         r_dc_goal         <= i_cfg_data[LEVEL_W-1:0];
                REG_DRIVE_MIN:       r_drive_min       <= i_cfg_data[DRIVE_W-1:0];
                REG_DRIVE_MAX:       r_drive_max       <= i_cfg_data[DRIVE_W-1:0];
                REG_SETTLE_MS:       r_settle_ms       <= i_cfg_data[SETTLE_W-1:0];
                default: ;
            endcase
        end
    end

    // Drive state, flags and divider counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_drive   <= RST_DEFAULT_CURRENT;
            r_last_ms <= '0;
            r_cnt     <= '0;
            r_chg     <= 1'b0;
            r_flush   <= 1'b0;
        end else begin
            unique case (w_ctrl.op)
                OP_LOAD: begin
                    if (w_s_acc) begin
                        r_chg   <= 1'b0;
                        r_flush <= 1'b0;
                    end
                end
                OP_PREP: begin
                    r_cnt <= CNT_W'(DIV_STEPS);
                end
                OP_DIV: begin
                    r_cnt <= r_cnt - CNT_W'(1);
                end
                OP_CLAMP: begin
                    if (w_limited != r_drive) begin
                        r_drive   <= w_limited;
                        r_last_ms <= r_now;
                        r_chg     <= 1'b1;
                        r_flush   <= 1'b1;
                    end
                end
                OP_RESTORE: begin
                    if (r_drive != r_default_current) begin
                        r_drive   <= r_default_current;
                        r_last_ms <= r_now;
                        r_chg     <= 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    // Item capture and divider datapath
    always_ff @(posedge i_clk) begin
        unique case (w_ctrl.op)
            OP_LOAD: begin
                if (w_s_acc) begin
                    r_level <= i_s_tdata[LEVEL_W-1:0];
                    r_now   <= i_s_tdata[LEVEL_W +: TIME_W];
                    r_worn  <= i_s_tuser;
                end
            end
            OP_PREP: begin
                r_quo <= PROD_W'(r_drive) * PROD_W'(r_dc_goal);
                r_rem <= '0;
                r_eff <= (r_level >= SAT_LEVEL)
                         ? EFF_W'(r_level) + EFF_W'(r_level >> 1)
                         : EFF_W'(r_level);
            end
            OP_DIV: begin
                r_quo <= {r_quo[PROD_W-2:0], w_q_bit};
                r_rem <= w_q_bit ? w_rem_sub[EFF_W-1:0] : w_rem_sh[EFF_W-1:0];
            end
            default: ;
        endcase
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (w_ctrl.op == OP_EMIT && !w_stat.out_blocked) begin
            r_m_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ctrl.op == OP_EMIT && !w_stat.out_blocked) begin
            r_m_data <= M_DATA_W'({r_flush, r_drive, r_chg});
        end
    end

    // A flush request never comes without a drive change
    a_flush_implies_chg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (!o_m_tdata[DRIVE_W+1] || o_m_tdata[0]))
        else $error("flush_fifo set without changed");

    // The divider counter runs only under division steps
    a_cnt_only_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt != '0) |-> (w_ctrl.op == OP_DIV))
        else $error("divider counter active outside division");

    // Clamp sees a finished quotient
    a_clamp_after_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_ctrl.op == OP_CLAMP) |-> (r_cnt == '0) && ($past(w_ctrl.op) == OP_DIV))
        else $error("clamp before division finished");

    // An unblocked emit step presents a result next cycle
    a_emit_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_ctrl.op == OP_EMIT && !w_stat.out_blocked) |=> o_m_tvalid)
        else $error("emitted result not presented");

endmodule

// ----- tb/tb_led_current_auto_gain.sv -----
`timescale 1ns / 100ps

module tb_led_current_auto_gain;
    import lcag_pkg::*;

    localparam int unsigned CYCLE_LIMIT  = 400000;
    localparam int unsigned LONG_HOLD    = 400;
    localparam int unsigned DRAIN_CYCLES = 40;
    localparam int unsigned MAX_GAP      = 16;
    localparam int unsigned MAX_REPORTS  = 10;
    // Index past the last register, must be ignored
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
    // Saturated readings are scaled by SAT_MUL / SAT_DIV
    localparam int unsigned SAT_MUL = 3;
    localparam int unsigned SAT_DIV = 2;

    // Output fields, lowest bit last
    typedef struct packed {
        logic               flush_fifo;
        logic [DRIVE_W-1:0] drive;
        logic               changed;
    } t_drive_result;

    // Tracks drive state and configuration, predicts one result per input
    class drive_ledger;
        logic [DRIVE_W-1:0]  default_current;
        logic [LEVEL_W-1:0]  band_low;
        logic [LEVEL_W-1:0]  band_high;
        logic [LEVEL_W-1:0]  dc_goal;
        logic [DRIVE_W-1:0]  drive_min;
        logic [DRIVE_W-1:0]  drive_max;
        logic [SETTLE_W-1:0] settle_ms;
        logic [DRIVE_W-1:0]  drive_now;
        logic [TIME_W-1:0]   last_change_ms;
        t_drive_result       pending_drive[$];
        int unsigned         fails;

        function new();
            default_current = RST_DEFAULT_CURRENT;
            band_low        = RST_BAND_LOW;
            band_high       = RST_BAND_HIGH;
            dc_goal         = RST_DC_GOAL;
            drive_min       = RST_DRIVE_MIN;
            drive_max       = RST_DRIVE_MAX;
            settle_ms       = RST_SETTLE_MS;
            drive_now       = RST_DEFAULT_CURRENT;
            last_change_ms  = '0;
            fails           = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_DEFAULT_CURRENT: default_current = data[DRIVE_W-1:0];
                REG_BAND_LOW:        band_low        = data[LEVEL_W-1:0];
                REG_BAND_HIGH:       band_high       = data[LEVEL_W-1:0];
                REG_DC_GOAL:         dc_goal         = data[LEVEL_W-1:0];
                REG_DRIVE_MIN:       drive_min       = data[DRIVE_W-1:0];
                REG_DRIVE_MAX:       drive_max       = data[DRIVE_W-1:0];
                REG_SETTLE_MS:       settle_ms       = data[SETTLE_W-1:0];
                default: ;
            endcase
        endfunction

        // Note an accepted input and queue the drive result it must produce
        function void predict_drive(logic [LEVEL_W-1:0] level, logic worn,
                                    logic [TIME_W-1:0] stamp);
            t_drive_result r;
            logic [TIME_W-1:0] elapsed;
            logic [63:0] eff;
            logic [63:0] est;
            r = '0;
            elapsed = stamp - last_change_ms;
            if (!worn) begin
                // off skin: fall back to the default drive
                if (drive_now != default_current) begin
                    drive_now      = default_current;
                    last_change_ms = stamp;
                    r.changed      = 1'b1;
                end
            end else if (elapsed >= TIME_W'(settle_ms)
                         && !(level >= band_low && level <= band_high)
                         && level != '0) begin
                // proportional step toward the goal, saturated readings scaled up
                eff = 64'(level);
                if (level >= SAT_LEVEL)
                    eff = eff * SAT_MUL / SAT_DIV;
                est = 64'(drive_now) * 64'(dc_goal) / eff;
                if (est < 64'(drive_min)) est = 64'(drive_min);
                if (est > 64'(drive_max)) est = 64'(drive_max);
                if (est != 64'(drive_now)) begin
                    drive_now      = est[DRIVE_W-1:0];
                    last_change_ms = stamp;
                    r.changed      = 1'b1;
                    r.flush_fifo   = 1'b1;
                end
            end
            r.drive = drive_now;
            pending_drive.push_back(r);
        endfunction

        // Compare one output transaction against the oldest prediction
        function void check_drive(logic [M_DATA_W-1:0] data);
            t_drive_result got;
            t_drive_result want;
            got = data[$bits(t_drive_result)-1:0];
            if (pending_drive.size() == 0) begin
                fails++;
                if (fails <= MAX_REPORTS)
                    $display("unexpected output transaction: tdata=%h", data);
                return;
            end
            want = pending_drive.pop_front();
            if (got.changed != want.changed || got.drive != want.drive
                || got.flush_fifo != want.flush_fifo) begin
                fails++;
                if (fails <= MAX_REPORTS)
                    $display("drive mismatch: expected changed=%0d drive=%0d flush=%0d, %s%0d %s%0d %s%0d",
                             want.changed, want.drive, want.flush_fifo,
                             "got changed=", got.changed, "drive=", got.drive,
                             "flush=", got.flush_fifo);
            end
        endfunction

        function int pending();
            return pending_drive.size();
        endfunction
    endclass

    logic                  i_clk;
    logic                  i_rst_n     = 1'b0;
    logic                  i_s_tvalid  = 1'b0;
    logic                  o_s_tready;
    logic [S_DATA_W-1:0]   i_s_tdata   = '0;
    logic                  i_s_tuser   = 1'b0;
    logic                  o_m_tvalid;
    logic                  i_m_tready  = 1'b0;
    logic [M_DATA_W-1:0]   o_m_tdata;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data  = '0;

    drive_ledger       ledger;
    int unsigned       src_max_gap   = MAX_GAP;
    int unsigned       sink_max_gap  = MAX_GAP;
    bit                sink_hold_req = 1'b0;
    logic [TIME_W-1:0] now_stamp     = '0;

    led_current_auto_gain u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Run limit
    initial begin
        int unsigned cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("tb_led_current_auto_gain NOT OK");
        $finish;
    end

    // Output monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready)
            ledger.check_drive(o_m_tdata);
    end

    // Receiver: random stalls per result, long hold on request
    initial begin
        int unsigned stall;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            if (sink_hold_req) begin
                i_m_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
                sink_hold_req = 1'b0;
            end else begin
                stall = $urandom_range(0, sink_max_gap);
                if (stall > 0) begin
                    i_m_tready <= 1'b0;
                    repeat (stall) @(posedge i_clk);
                end
            end
            i_m_tready <= 1'b1;
            do @(posedge i_clk);
            while (!(o_m_tvalid && i_m_tready) && !sink_hold_req);
        end
    end

    // One input transaction; valid stays up when the next gap is zero
    task automatic send_item(input logic [LEVEL_W-1:0] level, input logic worn,
                             input logic [TIME_W-1:0] stamp);
        int unsigned gap;
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {{(S_DATA_W - LEVEL_W - TIME_W){1'b0}}, stamp, level};
        i_s_tuser  <= worn;
        do @(posedge i_clk); while (!o_s_tready);
        ledger.predict_drive(level, worn, stamp);
        gap = $urandom_range(0, src_max_gap);
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Stop offering and wait until every result is back
    task automatic wait_drained();
        i_s_tvalid <= 1'b0;
        while (ledger.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        ledger.set_reg(idx, value);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic apply_settings(input logic [CFG_DATA_W-1:0] dflt, lo, hi, goal,
                                  mn, mx, settle);
        wait_drained();
        write_reg(REG_DEFAULT_CURRENT, dflt);
        write_reg(REG_BAND_LOW, lo);
        write_reg(REG_BAND_HIGH, hi);
        write_reg(REG_DC_GOAL, goal);
        write_reg(REG_DRIVE_MIN, mn);
        write_reg(REG_DRIVE_MAX, mx);
        write_reg(REG_SETTLE_MS, settle);
    endtask

    // Levels biased out of band so corrections happen often
    function automatic logic [LEVEL_W-1:0] pick_level();
        logic [LEVEL_W-1:0] lo;
        logic [LEVEL_W-1:0] hi;
        lo = ledger.band_low;
        hi = ledger.band_high;
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return LEVEL_W'(1);
            2:       return LEVEL_W'($urandom_range(260000, 262143));
            3:       return LEVEL_W'($urandom_range(0, lo));
            4:       return LEVEL_W'($urandom_range(hi, 262143));
            5:       return LEVEL_W'($urandom_range(lo, hi));
            6:       return lo - LEVEL_W'(1);
            7:       return hi + LEVEL_W'(1);
            default: return LEVEL_W'($urandom);
        endcase
    endfunction

    // Timestamps mostly move forward around the settle time; some jumps and wraps
    function automatic logic [TIME_W-1:0] next_stamp(input logic [TIME_W-1:0] stamp);
        case ($urandom_range(0, 15))
            0:       return $urandom;
            1:       return stamp - $urandom_range(1, 5000);
            2:       return stamp;
            3:       return 32'hFFFF_FFFF - $urandom_range(0, 3000);
            default: return stamp + $urandom_range(0, 2 * ledger.settle_ms + 2);
        endcase
    endfunction

    task automatic run_random(input int unsigned count);
        for (int unsigned k = 0; k < count; k++) begin
            // stretches without idling on either side
            src_max_gap  = ((k / 30) % 3 == 2) ? 0 : MAX_GAP;
            sink_max_gap = ((k / 45) % 3 == 1) ? 0 : MAX_GAP;
            now_stamp = next_stamp(now_stamp);
            send_item(pick_level(), ($urandom_range(0, 99) < 85), now_stamp);
        end
        src_max_gap  = MAX_GAP;
        sink_max_gap = MAX_GAP;
    endtask

    // Directed cases under reset configuration
    task automatic run_directed();
        send_item(18'd0,      1'b0, 32'd0);          // off skin, already default
        send_item(18'd10000,  1'b1, 32'd500);        // inside settle window
        send_item(18'd10000,  1'b1, 32'd1000);       // settle edge, low level, clamp high
        send_item(18'd10000,  1'b1, 32'd2500);       // clamped value equals current
        send_item(18'd100000, 1'b1, 32'd5000);       // in band
        send_item(18'd0,      1'b1, 32'd9000);       // zero level
        send_item(18'h3FFFF,  1'b1, 32'd9000);       // saturated maximum
        send_item(18'd260000, 1'b1, 32'd20000);      // saturation threshold
        send_item(18'd259999, 1'b1, 32'd30000);      // just under threshold
        send_item(18'd50000,  1'b1, 32'd40000);      // lower band edge
        send_item(18'd200000, 1'b1, 32'd50000);      // upper band edge
        send_item(18'd49999,  1'b1, 32'd60000);
        send_item(18'd200001, 1'b1, 32'd70000);
        send_item(18'd1,      1'b1, 32'd80000);      // tiny level
        send_item(18'd150000, 1'b0, 32'd80500);      // off skin, restore default
        send_item(18'd150000, 1'b0, 32'd81000);      // off skin, no change
        send_item(18'd1000,   1'b1, 32'd81500);      // settle edge since the restore, low level, clamp high
        send_item(18'd1000,   1'b1, 32'd5);          // time runs backwards
        send_item(18'h3FFFF,  1'b1, 32'hFFFF_FFFF);
        send_item(18'h3FFFF,  1'b1, 32'h0000_0100);  // wrapped, still settling
        send_item(18'd240000, 1'b1, 32'h0001_0000);
        now_stamp = 32'h0002_0000;
    endtask

    // Stimulus
    initial begin
        ledger = new();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        run_directed();

        apply_settings(31, 50000, 200000, 120000, 1, 255, 0);
        run_random(55);
        wait_drained();
        run_random(55);

        // widest goal, band holding only zero, longest settle
        apply_settings(0, 0, 0, 262143, 0, 255, 65535);
        run_random(60);

        // zero goal, min above max
        apply_settings(255, 262143, 262143, 0, 200, 100, 1);
        run_random(60);

        // block fills while the receiver holds off
        apply_settings(128, 100000, 150000, 125000, 5, 250, 100);
        sink_hold_req = 1'b1;
        run_random(110);

        // inverted band, drive limits pinned at zero
        apply_settings(17, 200000, 50000, 1, 0, 0, 0);
        run_random(50);

        // random configuration, plus a write to an unused index
        wait_drained();
        write_reg(REG_UNUSED, CFG_DATA_W'($urandom));
        write_reg(REG_DEFAULT_CURRENT, CFG_DATA_W'($urandom));
        write_reg(REG_BAND_LOW, CFG_DATA_W'($urandom_range(0, 120000)));
        write_reg(REG_BAND_HIGH, CFG_DATA_W'($urandom_range(120000, 262143)));
        write_reg(REG_DC_GOAL, CFG_DATA_W'($urandom));
        write_reg(REG_DRIVE_MIN, CFG_DATA_W'($urandom_range(0, 60)));
        write_reg(REG_DRIVE_MAX, CFG_DATA_W'($urandom_range(100, 255)));
        write_reg(REG_SETTLE_MS, CFG_DATA_W'($urandom_range(0, 3000)));
        run_random(140);

        wait_drained();
        if (ledger.fails == 0 && ledger.pending() == 0)
            $display("tb_led_current_auto_gain OK");
        else
            $display("tb_led_current_auto_gain NOT OK");
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/lcag_pkg.sv
rtl/lcag_seq.sv
rtl/led_current_auto_gain.sv
tb/tb_led_current_auto_gain.sv
